// File: rtl/wef_pkg.sv
// ----------------------------------------------------------------------------
// wef_pkg
// Shared types, constants and helpers for the waveform envelope filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wef_pkg;

   localparam int POINTS      = 32;
   localparam int TABLE_DEPTH = 32;
   localparam int TAB_W       = 5;
   localparam int POS_W       = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int INS_W       = $clog2(POINTS + 1);
   localparam int SAMPLE_W    = 16;
   localparam int COUNT_W     = 32;

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 64;

   localparam logic OP_LIMIT  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic                       op;
      logic [TAB_W-1:0]           point_index;
      logic signed [SAMPLE_W-1:0] lower_limit;
      logic signed [SAMPLE_W-1:0] upper_limit;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic               keep;
      logic [COUNT_W-1:0] kept_count;
      logic [COUNT_W-1:0] seen_count;
   } result_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      sat_inc = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
   endfunction

endpackage

`default_nettype wire

// File: rtl/wef_limit_table.sv
// ----------------------------------------------------------------------------
// wef_limit_table
// Per-point lower and upper limit storage: one write port, one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wef_limit_table (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [wef_pkg::TAB_W-1:0]           wr_index,
   input  wire logic signed [wef_pkg::SAMPLE_W-1:0] wr_lower,
   input  wire logic signed [wef_pkg::SAMPLE_W-1:0] wr_upper,
   input  wire logic [wef_pkg::TAB_W-1:0]           rd_index,
   output logic signed [wef_pkg::SAMPLE_W-1:0]      rd_lower,
   output logic signed [wef_pkg::SAMPLE_W-1:0]      rd_upper
);

   logic signed [wef_pkg::SAMPLE_W-1:0] lower_ff [wef_pkg::TABLE_DEPTH];
   logic signed [wef_pkg::SAMPLE_W-1:0] upper_ff [wef_pkg::TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lower_ff[wr_index] <= wr_lower;
         upper_ff[wr_index] <= wr_upper;
      end
   end

   assign rd_lower = lower_ff[rd_index];
   assign rd_upper = upper_ff[rd_index];

endmodule

`default_nettype wire

// File: rtl/wef_mask_check.sv
// ----------------------------------------------------------------------------
// wef_mask_check
// Point position, per-waveform accumulators and saturating waveform totals.
// ----------------------------------------------------------------------------
`default_nettype none

module wef_mask_check (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                step,
   input  wire logic                                reject_outside_mode,
   input  wire logic signed [wef_pkg::SAMPLE_W-1:0] sample,
   input  wire logic signed [wef_pkg::SAMPLE_W-1:0] lower,
   input  wire logic signed [wef_pkg::SAMPLE_W-1:0] upper,
   output logic [wef_pkg::TAB_W-1:0]                table_index,
   output logic                                     last_point,
   output wef_pkg::result_type                      result
);

   logic [wef_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                        outside_ff, outside_in;
   logic [wef_pkg::INS_W-1:0]   inside_ff, inside_in;
   logic [wef_pkg::COUNT_W-1:0] kept_total_ff, kept_total_in;
   logic [wef_pkg::COUNT_W-1:0] seen_total_ff, seen_total_in;

   logic                        is_outside;
   logic                        is_inside;
   logic                        outside_now;
   logic [wef_pkg::INS_W-1:0]   inside_now;
   logic                        keep;

   assign table_index = wef_pkg::TAB_W'(pos_ff);
   assign last_point  = (pos_ff == wef_pkg::POS_W'(wef_pkg::POINTS - 1));

   assign is_outside  = (sample < lower) || (sample > upper);
   assign is_inside   = (sample > lower) && (sample < upper);
   assign outside_now = outside_ff | is_outside;
   assign inside_now  = inside_ff + wef_pkg::INS_W'(is_inside);

   always_comb begin
      if (reject_outside_mode) begin
         keep = !outside_now;
      end else begin
         keep = (inside_now != wef_pkg::INS_W'(wef_pkg::POINTS));
      end
   end

   assign seen_total_in = wef_pkg::sat_inc(seen_total_ff);
   assign kept_total_in = keep ? wef_pkg::sat_inc(kept_total_ff) : kept_total_ff;

   assign result.keep       = keep;
   assign result.kept_count = kept_total_in;
   assign result.seen_count = seen_total_in;

   // clear the accumulators once the waveform closes
   always_comb begin
      if (last_point) begin
         pos_in     = '0;
         outside_in = 1'b0;
         inside_in  = '0;
      end else begin
         pos_in     = pos_ff + wef_pkg::POS_W'(1);
         outside_in = outside_now;
         inside_in  = inside_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         outside_ff    <= 1'b0;
         inside_ff     <= '0;
         kept_total_ff <= '0;
         seen_total_ff <= '0;
      end else if (step) begin
         pos_ff     <= pos_in;
         outside_ff <= outside_in;
         inside_ff  <= inside_in;
         if (last_point) begin
            kept_total_ff <= kept_total_in;
            seen_total_ff <= seen_total_in;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_kept_le_seen: assert property (@(posedge clock) disable iff (reset)
      kept_total_ff <= seen_total_ff)
      else $error("kept total exceeds seen total");

   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      (step && last_point) |=> (pos_ff == '0 && inside_ff == '0 && !outside_ff))
      else $error("accumulators not cleared after last point");

   a_seen_inc: assert property (@(posedge clock) disable iff (reset)
      (step && last_point && seen_total_ff != wef_pkg::COUNT_MAX)
      |=> (seen_total_ff == $past(seen_total_ff) + wef_pkg::COUNT_W'(1)))
      else $error("seen total did not advance on waveform end");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= wef_pkg::POS_W'(wef_pkg::POINTS - 1))
      else $error("point position out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/waveform_envelope_filter.sv
// ----------------------------------------------------------------------------
// waveform_envelope_filter
// Envelope test of spike waveforms against per-point limit tables.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle unless a closing sample is held
// back by an unread result. A word is either a limit write (tuser 0), which
// stores the lower and upper limit of one point, or a sample (tuser 1);
// samples are placed by an internal point counter, and after the last point
// of a waveform one result word carries the keep flag and the saturating
// kept and seen totals. Each word passes an input register and then compare
// and count logic into the result register; a last sample waits in the
// input register only while an unread result still holds the output. Limit
// tables are flip-flop arrays read at the current point in the same cycle;
// every point must be written before a waveform uses it. Write the mode
// register only while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_envelope_filter (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                csr_wr_en,
   input  wire logic                                csr_wr_data,   // reject_outside_mode

   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // point_index[4:0], lower_limit[20:5], upper_limit[36:21], sample[52:37]
   input  wire logic [wef_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  wire logic                                req_tuser,     // op

   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // kept_count[31:0], seen_count[63:32]
   output logic [wef_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   output logic                                     rsp_tuser      // keep
);

   logic                 mode_ff;
   wef_pkg::req_type     req_ff, req_in;
   logic                 req_vld_ff, req_vld_in;
   wef_pkg::result_type  rsp_ff;
   logic                 rsp_vld_ff;

   logic                 is_sample;
   logic                 needs_out;
   logic                 out_free;
   logic                 fire;
   logic                 last_point;
   logic [wef_pkg::TAB_W-1:0]           table_index;
   logic signed [wef_pkg::SAMPLE_W-1:0] rd_lower;
   logic signed [wef_pkg::SAMPLE_W-1:0] rd_upper;
   wef_pkg::result_type  result;

   assign req_in.op          = req_tuser;
   assign req_in.point_index = req_tdata[4:0];
   assign req_in.lower_limit = req_tdata[20:5];
   assign req_in.upper_limit = req_tdata[36:21];
   assign req_in.sample      = req_tdata[52:37];

   assign is_sample  = (req_ff.op == wef_pkg::OP_SAMPLE);
   assign needs_out  = is_sample && last_point;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign fire       = req_vld_ff && (!needs_out || out_free);
   assign req_tready = !req_vld_ff || fire;
   assign req_vld_in = req_tready ? req_tvalid : req_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_in;
      end
   end

   wef_limit_table u_limit_table (
      .clock    (clock),
      .wr_en    (fire && !is_sample),
      .wr_index (req_ff.point_index),
      .wr_lower (req_ff.lower_limit),
      .wr_upper (req_ff.upper_limit),
      .rd_index (table_index),
      .rd_lower (rd_lower),
      .rd_upper (rd_upper)
   );

   wef_mask_check u_mask_check (
      .clock               (clock),
      .reset               (reset),
      .step                (fire && is_sample),
      .reject_outside_mode (mode_ff),
      .sample              (req_ff.sample),
      .lower               (rd_lower),
      .upper               (rd_upper),
      .table_index         (table_index),
      .last_point          (last_point),
      .result              (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fire && needs_out) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && needs_out) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_ff.keep;
   assign rsp_tdata  = {rsp_ff.seen_count, rsp_ff.kept_count};

`ifndef NO_ASSERTIONS
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_vld_ff && !fire) |=> (req_vld_ff && $stable(req_ff)))
      else $error("pending word lost while stalled");

   a_result_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_vld_ff || rsp_tready) && !(fire && needs_out) |=> !rsp_vld_ff)
      else $error("result word raised without a closing sample");

   a_rsp_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_ff.kept_count <= rsp_ff.seen_count))
      else $error("result kept count exceeds seen count");
`endif

endmodule

`default_nettype wire

// File: test/waveform_envelope_filter_test.sv
// ----------------------------------------------------------------------------
// waveform_envelope_filter_test
// Self-checking bench for the spike waveform envelope filter.
// ----------------------------------------------------------------------------
// Loads the limit tables, runs a short list of hand-built waveforms whose keep
// flag is known by inspection, then streams random waveforms in phases with
// mode changes between them (some land mid-waveform). A local envelope
// predictor tracks tables, point position and totals and queues the verdict
// expected after each last point; result words are checked in order. Both
// sides of the stream throttle at random.
// ----------------------------------------------------------------------------

module waveform_envelope_filter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import wef_pkg::*;

   localparam int TOTAL_WORDS  = 1950;
   localparam int QUIET_LIMIT  = 3000;
   localparam int REPORT_MAX   = 10;
   localparam logic signed [SAMPLE_W-1:0] S_MIN = -16'sd32768;
   localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] BASE_LO = -16'sd1000;
   localparam logic signed [SAMPLE_W-1:0] BASE_HI = 16'sd1000;

   typedef enum logic [2:0] {
      PAT_ZERO, PAT_AT_LOWER, PAT_AT_UPPER, PAT_MIN_AT, PAT_MAX_AT, PAT_ALL_MIN, PAT_ALL_MAX
   } pattern_type;

   typedef enum logic [1:0] {STY_INSIDE, STY_MIXED, STY_NOISE} wave_style_type;

   // mode at start, sample pattern, special point, rewrite entry at that point
   // mid-waveform, flip mode at point 16, keep flag known by inspection
   typedef struct packed {
      logic        mode;
      pattern_type pat;
      logic [4:0]  pt;
      logic        rewrite;
      logic        toggle;
      logic        keep;
   } drill_row_type;

   localparam int DRILLS = 13;
   drill_row_type drills [DRILLS] = '{
      '{1'b1, PAT_ZERO,     5'd0,  1'b0, 1'b0, 1'b1},
      '{1'b1, PAT_AT_LOWER, 5'd0,  1'b0, 1'b0, 1'b1},
      '{1'b1, PAT_AT_UPPER, 5'd0,  1'b0, 1'b0, 1'b1},
      '{1'b1, PAT_MIN_AT,   5'd0,  1'b0, 1'b0, 1'b0},
      '{1'b1, PAT_MAX_AT,   5'd31, 1'b0, 1'b0, 1'b0},
      '{1'b1, PAT_MAX_AT,   5'd20, 1'b1, 1'b0, 1'b1},
      '{1'b0, PAT_ZERO,     5'd0,  1'b0, 1'b0, 1'b0},
      '{1'b0, PAT_AT_UPPER, 5'd0,  1'b0, 1'b0, 1'b1},
      '{1'b0, PAT_MAX_AT,   5'd7,  1'b0, 1'b0, 1'b1},
      '{1'b0, PAT_ALL_MIN,  5'd0,  1'b0, 1'b0, 1'b1},
      '{1'b1, PAT_ALL_MAX,  5'd0,  1'b0, 1'b0, 1'b0},
      '{1'b1, PAT_ZERO,     5'd0,  1'b0, 1'b1, 1'b0},
      '{1'b0, PAT_ZERO,     5'd0,  1'b0, 1'b1, 1'b1}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic                   csr_wr_data = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   // envelope predictor state
   logic signed [SAMPLE_W-1:0] lim_lo [TABLE_DEPTH];
   logic signed [SAMPLE_W-1:0] lim_hi [TABLE_DEPTH];
   logic [TAB_W-1:0]           pt_pos = '0;
   logic                       any_outside = 1'b0;
   int                         n_inside = 0;
   logic [COUNT_W-1:0]         kept_tot = '0;
   logic [COUNT_W-1:0]         seen_tot = '0;
   logic                       mode_reject_out = 1'b1;
   result_type                 verdict_q [$];

   int error_count = 0;
   int words_sent = 0;
   int burst_left = 0;
   int quiet_cycles = 0;
   int rdy_pct = 100;
   int rdy_seg = 0;

   waveform_envelope_filter u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void predict_envelope(input logic op, input logic [TAB_W-1:0] idx,
                                            input logic signed [SAMPLE_W-1:0] lo,
                                            input logic signed [SAMPLE_W-1:0] hi,
                                            input logic signed [SAMPLE_W-1:0] smp);
      result_type verdict;
      logic signed [SAMPLE_W-1:0] tlo;
      logic signed [SAMPLE_W-1:0] thi;
      if (op == OP_LIMIT) begin
         lim_lo[idx] = lo;
         lim_hi[idx] = hi;
         return;
      end
      tlo = lim_lo[pt_pos];
      thi = lim_hi[pt_pos];
      if (smp < tlo || smp > thi) any_outside = 1'b1;
      if (smp > tlo && smp < thi) n_inside++;
      if (int'(pt_pos) != POINTS - 1) begin
         pt_pos++;
         return;
      end
      verdict.keep = mode_reject_out ? !any_outside : (n_inside != POINTS);
      if (seen_tot != COUNT_MAX) seen_tot++;
      if (verdict.keep && kept_tot != COUNT_MAX) kept_tot++;
      verdict.kept_count = kept_tot;
      verdict.seen_count = seen_tot;
      verdict_q.push_back(verdict);
      pt_pos = '0;
      any_outside = 1'b0;
      n_inside = 0;
   endfunction

   task automatic send_word(input logic op, input logic [TAB_W-1:0] idx,
                            input logic signed [SAMPLE_W-1:0] lo,
                            input logic signed [SAMPLE_W-1:0] hi,
                            input logic signed [SAMPLE_W-1:0] smp);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         // long bursts give stretches with no idling at all
         burst_left = ($urandom_range(99) < 15) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_W'({smp, hi, lo, idx});
      // look at tready mid-cycle, where it holds the value seen by the next edge
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      predict_envelope(op, idx, lo, hi, smp);
      words_sent++;
   endtask

   task automatic send_limit(input logic [TAB_W-1:0] idx, input logic signed [SAMPLE_W-1:0] lo,
                             input logic signed [SAMPLE_W-1:0] hi);
      send_word(OP_LIMIT, idx, lo, hi, SAMPLE_W'($urandom));
   endtask

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
      send_word(OP_SAMPLE, TAB_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom), smp);
   endtask

   // drain the pipe, then write the mode register
   task automatic set_mode(input logic m);
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      mode_reject_out = m;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] drill_sample(input drill_row_type row,
                                                               input int p);
      case (row.pat)
         PAT_AT_LOWER: return lim_lo[p];
         PAT_AT_UPPER: return lim_hi[p];
         PAT_MIN_AT:   return (p == int'(row.pt)) ? S_MIN : '0;
         PAT_MAX_AT:   return (p == int'(row.pt)) ? S_MAX : '0;
         PAT_ALL_MIN:  return S_MIN;
         PAT_ALL_MAX:  return S_MAX;
         default:      return '0;
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(input wave_style_type style);
      int lo;
      int hi;
      int roll;
      lo = int'(lim_lo[pt_pos]);
      hi = int'(lim_hi[pt_pos]);
      roll = $urandom_range(99);
      if (style == STY_NOISE) return SAMPLE_W'($urandom);
      if (style == STY_INSIDE && roll < 97) roll = 0;
      if (roll < 55 && hi - lo >= 2) return SAMPLE_W'(lo + 1 + $urandom_range(0, hi - lo - 2));
      if (roll < 65) return lim_lo[pt_pos];
      if (roll < 75) return lim_hi[pt_pos];
      if (roll < 85 && lo > -32768) return SAMPLE_W'(lo - 1 - $urandom_range(0, lo + 32767));
      if (roll < 95 && hi < 32767) return SAMPLE_W'(hi + 1 + $urandom_range(0, 32766 - hi));
      return SAMPLE_W'($urandom);
   endfunction

   task automatic refresh_limits();
      int lo;
      int hi;
      int roll;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         roll = $urandom_range(99);
         if (roll < 70) begin
            lo = -int'($urandom_range(0, 20000));
            hi = $urandom_range(0, 20000);
         end else if (roll < 90) begin
            // narrow window, often with no room strictly inside
            lo = int'($urandom_range(0, 65532)) - 32768;
            hi = lo + $urandom_range(0, 3);
         end else begin
            lo = int'(SAMPLE_W'($urandom));
            hi = int'(SAMPLE_W'($urandom));
         end
         send_limit(TAB_W'(i), SAMPLE_W'(lo), SAMPLE_W'(hi));
      end
   endtask

   // result check, sampled mid-cycle ahead of the accepting edge
   always @(negedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("unexpected result: keep %0b kept %0d seen %0d", rsp_tuser,
                        rsp_tdata[31:0], rsp_tdata[63:32]);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_tuser !== want.keep || rsp_tdata[31:0] !== want.kept_count ||
                rsp_tdata[63:32] !== want.seen_count) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("result mismatch: keep %0b/%0b kept %0d/%0d seen %0d/%0d (exp/got)",
                           want.keep, rsp_tuser, want.kept_count, rsp_tdata[31:0],
                           want.seen_count, rsp_tdata[63:32]);
            end
         end
      end
   end

   // receiver throttle
   always @(posedge clock) begin
      if (rdy_seg == 0) begin
         rdy_seg = $urandom_range(16, 120);
         case ($urandom_range(3))
            0: rdy_pct = 100;
            1: rdy_pct = 75;
            2: rdy_pct = 30;
            default: rdy_pct = 0;
         endcase
         if (rdy_pct == 0) rdy_seg = $urandom_range(4, 40);
      end
      rdy_seg--;
      rsp_tready <= ($urandom_range(99) < rdy_pct);
   end

   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("waveform_envelope_filter regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wave_style_type style;
      int n;
      drill_row_type row;
      style = STY_MIXED;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < TABLE_DEPTH; i++) send_limit(TAB_W'(i), BASE_LO, BASE_HI);

      // hand-built waveforms
      for (int r = 0; r < DRILLS; r++) begin
         row = drills[r];
         if (row.mode != mode_reject_out) set_mode(row.mode);
         for (int p = 0; p < POINTS; p++) begin
            if (row.toggle && p == POINTS / 2) set_mode(!mode_reject_out);
            if (row.rewrite && p == int'(row.pt)) send_limit(row.pt, S_MIN, S_MAX);
            send_sample(drill_sample(row, p));
         end
         verdict_q[verdict_q.size() - 1].keep = row.keep;
         if (row.rewrite) send_limit(row.pt, BASE_LO, BASE_HI);
      end

      // random phases; a phase may end in the middle of a waveform
      while (words_sent < TOTAL_WORDS) begin
         set_mode(1'($urandom_range(1)));
         if ($urandom_range(99) < 30) refresh_limits();
         n = $urandom_range(40, 300);
         repeat (n) begin
            if (words_sent >= TOTAL_WORDS) break;
            if (pt_pos == 0) begin
               case ($urandom_range(9))
                  0, 1, 2, 3: style = STY_INSIDE;
                  9:          style = STY_NOISE;
                  default:    style = STY_MIXED;
               endcase
            end
            if ($urandom_range(99) < 4)
               send_limit(TAB_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
            else
               send_sample(pick_sample(style));
         end
      end

      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("waveform_envelope_filter regression: pass");
      else
         $display("waveform_envelope_filter regression: fail");
      $finish;
   end

endmodule

// File: waveform_envelope_filter.f
rtl/wef_pkg.sv
rtl/wef_limit_table.sv
rtl/wef_mask_check.sv
rtl/waveform_envelope_filter.sv
test/waveform_envelope_filter_test.sv
